@@ src/esud_pkg.sv @@
// Shared types, codes and constant tables for the epoch-seconds to UTC date block.
// No dependencies; compiled first.
package esud_pkg;

    localparam int EPOCH_W = 31;
    localparam int REM_W   = 17;    // remainder of the constant divider, < 86400
    localparam int DAYS_W  = 15;    // whole days since epoch, <= 24855
    localparam int YEAR_W  = 11;

    // Shared multiplier: scaled dividend times reciprocal, or quotient times divisor
    localparam int MUL_A_W = 24;
    localparam int MUL_B_W = 25;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam logic [YEAR_W-1:0] EPOCH_YEAR = 11'd1970;
    localparam logic [3:0]        LAST_MONTH = 4'd11;
    localparam logic [3:0]        FEBRUARY   = 4'd1;
    localparam logic [DAYS_W-1:0] EPOCH_WDAY = 15'd4;    // 1970-01-01 was a Thursday

    // Divider phases
    typedef logic [1:0] div_sel_t;
    localparam div_sel_t DIV_DAY  = 2'd0;
    localparam div_sel_t DIV_HOUR = 2'd1;
    localparam div_sel_t DIV_MIN  = 2'd2;
    localparam div_sel_t DIV_WEEK = 2'd3;

    typedef struct packed {
        logic     load_in;
        logic     div_step;
        logic     div_end;
        div_sel_t div_sel;
        logic     year_step;
        logic     month_step;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic year_fits;
        logic month_fits;
    } sts_t;

    typedef struct packed {
        logic [5:0]        second;
        logic [5:0]        minute;
        logic [4:0]        hour;
        logic [4:0]        day_of_month;
        logic [3:0]        month_index;
        logic [YEAR_W-1:0] year;
        logic [2:0]        weekday;
    } date_t;

    function automatic logic [REM_W-1:0] div_divisor(input div_sel_t sel);
        logic [REM_W-1:0] d;
        case (sel)
            DIV_DAY:  d = 17'd86400;
            DIV_HOUR: d = 17'd3600;
            DIV_MIN:  d = 17'd60;
            DIV_WEEK: d = 17'd7;
            default:  d = 17'd86400;
        endcase
        return d;
    endfunction

    // Rounded-up reciprocals; exact over each phase's dividend range.
    //   day:  (t >> 7) * ceil(2^34 / 675) >> 34
    //   hour: (s >> 4) * ceil(2^21 / 225) >> 21
    //   min:  (s >> 2) * ceil(2^14 / 15)  >> 14
    //   week: w        * ceil(2^18 / 7)   >> 18
    function automatic logic [MUL_B_W-1:0] div_recip(input div_sel_t sel);
        logic [MUL_B_W-1:0] r;
        case (sel)
            DIV_DAY:  r = 25'd25451659;
            DIV_HOUR: r = 25'd9321;
            DIV_MIN:  r = 25'd1093;
            DIV_WEEK: r = 25'd37450;
            default:  r = 25'd25451659;
        endcase
        return r;
    endfunction

    // Common-year month lengths
    function automatic logic [4:0] month_days(input logic [3:0] m);
        logic [4:0] d;
        case (m)
            4'd1:    d = 5'd28;
            4'd3:    d = 5'd30;
            4'd5:    d = 5'd30;
            4'd8:    d = 5'd30;
            4'd10:   d = 5'd30;
            default: d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

@@ src/esud_epoch_if.sv @@
// Input channel: one beat carries a seconds count since the epoch.
// Depends on esud_pkg.
interface esud_epoch_if import esud_pkg::*;;
    logic               valid;
    logic               ready;
    logic [EPOCH_W-1:0] epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);
endinterface

@@ src/esud_date_if.sv @@
// Output channel: one beat carries a broken-down UTC date and time.
// Depends on esud_pkg.
interface esud_date_if import esud_pkg::*;;
    logic              valid;
    logic              ready;
    logic [5:0]        second;
    logic [5:0]        minute;
    logic [4:0]        hour;
    logic [4:0]        day_of_month;
    logic [3:0]        month_index;
    logic [YEAR_W-1:0] year;
    logic [2:0]        weekday;

    modport source (output valid, output second, output minute, output hour,
                    output day_of_month, output month_index, output year,
                    output weekday, input ready);
    modport sink   (input valid, input second, input minute, input hour,
                    input day_of_month, input month_index, input year,
                    input weekday, output ready);
endinterface

@@ src/esud_ctrl.sv @@
// Sequencer: runs the divider phases and the year/month walk, owns the handshakes.
// Depends on esud_pkg.
module esud_ctrl import esud_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    localparam logic [1:0] W_OFF   = 2'd0;
    localparam logic [1:0] W_YEAR  = 2'd1;
    localparam logic [1:0] W_MONTH = 2'd2;
    localparam logic [1:0] W_DONE  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [1:0]       walk_reg, walk_next;
    div_sel_t         sel_reg, sel_next;
    logic             quo_done_reg, quo_done_next;
    logic             div_on_reg, div_on_next;
    logic             out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        walk_next      = walk_reg;
        sel_next       = sel_reg;
        quo_done_next  = quo_done_reg;
        div_on_next    = div_on_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.div_sel    = sel_reg;
        in_ready       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in   = 1'b1;
                    sel_next      = DIV_DAY;
                    quo_done_next = 1'b0;
                    div_on_next   = 1'b1;
                    walk_next     = W_OFF;
                    state_next    = ST_RUN;
                end
            end
            ST_RUN:
            begin
                // each phase: quotient cycle, then remainder cycle
                if (div_on_reg)
                begin
                    if (!quo_done_reg)
                    begin
                        cmd.div_step  = 1'b1;
                        quo_done_next = 1'b1;
                    end
                    else
                    begin
                        cmd.div_end   = 1'b1;
                        quo_done_next = 1'b0;
                        if (sel_reg == DIV_WEEK)
                            div_on_next = 1'b0;
                        else
                            sel_next = sel_reg + 2'd1;
                        if (sel_reg == DIV_DAY)
                            walk_next = W_YEAR;
                    end
                end

                case (walk_reg)
                    W_YEAR:
                    begin
                        if (sts.year_fits)
                            walk_next = W_MONTH;
                        else
                            cmd.year_step = 1'b1;
                    end
                    W_MONTH:
                    begin
                        if (sts.month_fits)
                            walk_next = W_DONE;
                        else
                            cmd.month_step = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase

                if (!div_on_reg && walk_reg == W_DONE)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // output register free, or emptied in this same cycle
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            walk_reg      <= W_OFF;
            sel_reg       <= DIV_DAY;
            quo_done_reg  <= 1'b0;
            div_on_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            walk_reg      <= walk_next;
            sel_reg       <= sel_next;
            quo_done_reg  <= quo_done_next;
            div_on_reg    <= div_on_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ src/esud_datapath.sv @@
// Datapath: divider by constants (reciprocal multiply), year/month walk, result registers.
// Depends on esud_pkg.
module esud_datapath import esud_pkg::*;
(
    input  logic               clk,
    input  logic [EPOCH_W-1:0] epoch_seconds,
    input  cmd_t               cmd,
    output sts_t               sts,
    output date_t              date
);

    // divider: one shared multiplier, quotient then remainder per phase
    logic [EPOCH_W-1:0] secs_reg;
    logic [REM_W-1:0]   sod_reg;     // second of the day
    logic [11:0]        soh_reg;     // second of the hour
    logic [DAYS_W-1:0]  quo_reg;
    logic [REM_W-1:0]   div_low;     // low dividend bits, enough for the remainder
    logic [MUL_A_W-1:0] scaled;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  prod;
    logic [DAYS_W-1:0]  quo_calc;
    logic [REM_W-1:0]   rem;

    // walk and partial results
    logic [DAYS_W-1:0] total_reg;
    logic [DAYS_W-1:0] days_reg;
    logic [YEAR_W-1:0] year_reg;
    logic [3:0]        month_reg;
    logic [4:0]        hour_reg;
    logic [5:0]        minute_reg;
    logic [5:0]        second_reg;
    logic [2:0]        weekday_reg;
    logic [DAYS_W-1:0] wday_base;
    date_t             date_reg;

    logic       leap;
    logic [8:0] year_len;
    logic [4:0] month_len;

    always_comb
    begin
        case (cmd.div_sel)
            DIV_DAY:
            begin
                div_low = secs_reg[REM_W-1:0];
                scaled  = secs_reg[EPOCH_W-1:7];
            end
            DIV_HOUR:
            begin
                div_low = sod_reg;
                scaled  = MUL_A_W'(sod_reg[REM_W-1:4]);
            end
            DIV_MIN:
            begin
                div_low = REM_W'(soh_reg);
                scaled  = MUL_A_W'(soh_reg[11:2]);
            end
            DIV_WEEK:
            begin
                div_low = REM_W'(wday_base);
                scaled  = MUL_A_W'(wday_base);
            end
            default:
            begin
                div_low = secs_reg[REM_W-1:0];
                scaled  = secs_reg[EPOCH_W-1:7];
            end
        endcase
    end

    // quotient cycle: scaled * reciprocal; remainder cycle: quotient * divisor
    assign mul_a = cmd.div_end ? MUL_A_W'(quo_reg) : scaled;
    assign mul_b = cmd.div_end ? MUL_B_W'(div_divisor(cmd.div_sel)) : div_recip(cmd.div_sel);
    assign prod  = mul_a * mul_b;

    always_comb
    begin
        case (cmd.div_sel)
            DIV_DAY:  quo_calc = prod[34 +: DAYS_W];
            DIV_HOUR: quo_calc = prod[21 +: DAYS_W];
            DIV_MIN:  quo_calc = prod[14 +: DAYS_W];
            DIV_WEEK: quo_calc = prod[18 +: DAYS_W];
            default:  quo_calc = prod[34 +: DAYS_W];
        endcase
    end

    // remainder < divisor, so the low bits of the difference are exact
    assign rem = div_low - prod[REM_W-1:0];

    // Years reachable from a 31-bit count are 1970..2038; the only century
    // year in range is 2000, which is leap, so the rule reduces to mod 4.
    assign leap      = (year_reg[1:0] == 2'd0);
    assign year_len  = leap ? 9'd366 : 9'd365;
    assign month_len = month_days(month_reg) + 5'((leap && month_reg == FEBRUARY) ? 1 : 0);

    assign sts.year_fits  = (days_reg < DAYS_W'(year_len));
    assign sts.month_fits = (month_reg == LAST_MONTH) || (days_reg < DAYS_W'(month_len));

    assign wday_base = total_reg + EPOCH_WDAY;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
            secs_reg <= epoch_seconds;

        if (cmd.div_step)
            quo_reg <= quo_calc;

        if (cmd.div_end)
        begin
            case (cmd.div_sel)
                DIV_DAY:
                begin
                    total_reg <= quo_reg;
                    days_reg  <= quo_reg;
                    year_reg  <= EPOCH_YEAR;
                    month_reg <= '0;
                    sod_reg   <= rem;
                end
                DIV_HOUR:
                begin
                    hour_reg <= quo_reg[4:0];
                    soh_reg  <= rem[11:0];
                end
                DIV_MIN:
                begin
                    minute_reg <= quo_reg[5:0];
                    second_reg <= rem[5:0];
                end
                DIV_WEEK:
                begin
                    weekday_reg <= rem[2:0];
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.year_step)
        begin
            days_reg <= days_reg - DAYS_W'(year_len);
            year_reg <= year_reg + 11'd1;
        end
        else if (cmd.month_step)
        begin
            days_reg  <= days_reg - DAYS_W'(month_len);
            month_reg <= month_reg + 4'd1;
        end

        if (cmd.out_load)
        begin
            date_reg.second       <= second_reg;
            date_reg.minute       <= minute_reg;
            date_reg.hour         <= hour_reg;
            date_reg.day_of_month <= days_reg[4:0] + 5'd1;
            date_reg.month_index  <= month_reg;
            date_reg.year         <= year_reg;
            date_reg.weekday      <= weekday_reg;
        end
    end

    assign date = date_reg;

endmodule

@@ src/epoch_seconds_to_utc_date.sv @@
// Top level: Unix seconds to broken-down UTC date and time.
// Depends on esud_pkg, esud_epoch_if, esud_date_if, esud_ctrl, esud_datapath.
//
//  channel | dir | beat contents
//  --------+-----+---------------------------------------------------------------
//  epoch   | in  | epoch_seconds[30:0]
//  date    | out | second, minute, hour, day_of_month, month_index, year, weekday
//
// One item at a time. After the input beat, a constant divider runs four phases
// (days, hour, minute, weekday), each a reciprocal-multiply step for the quotient
// then a multiply-subtract step for the remainder. Once the day count is known
// it is walked down one year per cycle, then one month per cycle, each walk
// ending in a closing check. The date beat is loaded once both the divider and
// the walk are done; the next epoch beat is taken in the cycle after that load.
// Reset (rst_n, async, active low) clears the sequencer and the output valid.
// A stalled date beat holds in its output register; the next epoch beat is
// still taken and worked on, and waits for the register to drain before load.
module epoch_seconds_to_utc_date import esud_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    esud_epoch_if.sink        epoch,
    esud_date_if.source       date
);

    cmd_t  cmd;
    sts_t  sts;
    date_t result;

    // sequencer: handshakes, phase and walk control
    esud_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (epoch.valid),
        .in_ready  (epoch.ready),
        .out_valid (date.valid),
        .out_ready (date.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // arithmetic and result registers
    esud_datapath u_datapath (
        .clk           (clk),
        .epoch_seconds (epoch.epoch_seconds),
        .cmd           (cmd),
        .sts           (sts),
        .date          (result)
    );

    assign date.second       = result.second;
    assign date.minute       = result.minute;
    assign date.hour         = result.hour;
    assign date.day_of_month = result.day_of_month;
    assign date.month_index  = result.month_index;
    assign date.year         = result.year;
    assign date.weekday      = result.weekday;

endmodule

@@ sim/tb_epoch_seconds_to_utc_date.sv @@
// Self-checking testbench for epoch_seconds_to_utc_date: drives seconds-since-epoch beats,
// predicts the broken-down UTC date of each one and checks every date beat in order.
// Depends on esud_pkg, esud_epoch_if, esud_date_if and the block under test.
module tb_epoch_seconds_to_utc_date;
    import esud_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Calendar constants for the predictor
    localparam int unsigned SECS_PER_DAY  = 86400;
    localparam int unsigned SECS_PER_HOUR = 3600;
    localparam int unsigned SECS_PER_MIN  = 60;
    localparam int unsigned DAYS_PER_WEEK = 7;
    localparam int unsigned FIRST_WDAY    = 4;              // 1970-01-01 was a Thursday
    localparam int unsigned LATEST_SECS   = 32'h7FFF_FFFF;  // 2038-01-19 03:14:07
    localparam int unsigned MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    // Run control
    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_ITEMS = 1900;
    localparam int LONG_HOLD    = 300;   // receiver hold-off, long enough to back up the input
    localparam int TAIL_CYCLES  = 200;   // wait after the last expected date for stray beats
    localparam int IDLE_LIMIT   = 4000;  // cycles with no beat on either channel
    localparam int SHOW_FAILS   = 10;

    // Entries of the stimulus list: a seconds beat, or a marker the driver acts on
    typedef enum logic [1:0] {
        PEND_SECS,   // offer this seconds value
        PEND_DRAIN,  // stop sending until every expected date has come back
        PEND_HOLD    // tell the receiver to start its long hold-off
    } pend_kind_t;

    typedef struct {
        pend_kind_t         kind;
        logic [EPOCH_W-1:0] secs;
    } pend_item_t;

    typedef struct {
        logic [EPOCH_W-1:0] secs;
        date_t              date;
    } date_expect_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    esud_epoch_if epoch_ch ();
    esud_date_if  date_ch ();

    // TB-side drivers; initialized so no input is ever X
    logic               tx_valid = 1'b0;
    logic [EPOCH_W-1:0] tx_secs  = '0;
    logic               rx_ready = 1'b0;
    logic               hold_req = 1'b0;

    assign epoch_ch.valid         = tx_valid;
    assign epoch_ch.epoch_seconds = tx_secs;
    assign date_ch.ready          = rx_ready;

    // Handshake results of the last rising edge, read by the falling-edge processes
    logic in_taken  = 1'b0;
    logic out_taken = 1'b0;

    pend_item_t   pending_beats [$];
    date_expect_t dates_expected [$];
    int           fail_count = 0;
    int           idle_cycles = 0;

    epoch_seconds_to_utc_date dut (
        .clk   (clk),
        .rst_n (rst_n),
        .epoch (epoch_ch),
        .date  (date_ch)
    );

    always #10 clk = ~clk;

    //------------------------------------------------------------------
    // Predictor: Gregorian leap rule, year walk from 1970, then month walk
    //------------------------------------------------------------------
    function automatic bit leap_year(input int unsigned y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic date_t utc_date(input logic [EPOCH_W-1:0] secs);
        date_t       d;
        int unsigned total_days;
        int unsigned sod;
        int unsigned days;
        int unsigned y;
        int unsigned m;
        int unsigned span;
        total_days = secs / SECS_PER_DAY;
        sod        = secs % SECS_PER_DAY;
        days       = total_days;
        y          = EPOCH_YEAR;
        m          = 0;
        // whole years
        span = leap_year(y) ? 366 : 365;
        while (days >= span) begin
            days -= span;
            y++;
            span = leap_year(y) ? 366 : 365;
        end
        // whole months; December is never subtracted
        while (m < LAST_MONTH) begin
            span = MONTH_LEN[m] + ((m == FEBRUARY && leap_year(y)) ? 1 : 0);
            if (days < span)
                break;
            days -= span;
            m++;
        end
        d.second       = 6'(sod % SECS_PER_MIN);
        d.minute       = 6'((sod / SECS_PER_MIN) % 60);
        d.hour         = 5'(sod / SECS_PER_HOUR);
        d.day_of_month = 5'(days + 1);
        d.month_index  = 4'(m);
        d.year         = YEAR_W'(y);
        d.weekday      = 3'((total_days + FIRST_WDAY) % DAYS_PER_WEEK);
        return d;
    endfunction

    task automatic note_fail(input string what);
        fail_count++;
        if (fail_count <= SHOW_FAILS)
            $display("[%0t] %s", $time, what);
    endtask

    task automatic push_secs(input int unsigned secs);
        pending_beats.push_back('{kind: PEND_SECS, secs: EPOCH_W'(secs)});
    endtask

    task automatic push_marker(input pend_kind_t kind);
        pending_beats.push_back('{kind: kind, secs: '0});
    endtask

    // Random seconds value, weighted toward calendar boundaries
    function automatic logic [EPOCH_W-1:0] random_secs();
        int unsigned pick;
        int unsigned t;
        int unsigned month_start;
        date_t       d;
        pick = $urandom_range(0, 99);
        t    = $urandom_range(0, LATEST_SECS);
        if (pick < 45)
            return EPOCH_W'(t);
        if (pick < 80) begin
            // back up to midnight on the first of t's month, then land near it
            d = utc_date(EPOCH_W'(t));
            month_start = t - (d.day_of_month - 1) * SECS_PER_DAY - t % SECS_PER_DAY;
            case ($urandom_range(0, 3))
                0: return EPOCH_W'(month_start);
                1: return EPOCH_W'((month_start == 0) ? 0 : month_start - 1);   // last second of prior month
                2: return EPOCH_W'((month_start + SECS_PER_DAY - 1 > LATEST_SECS) ?
                                   LATEST_SECS : month_start + SECS_PER_DAY - 1);
                default: return EPOCH_W'(month_start + $urandom_range(0, 3) * SECS_PER_DAY
                                         + $urandom_range(0, SECS_PER_DAY - 1));
            endcase
        end
        if (pick < 90)
            return EPOCH_W'($urandom_range(0, 4 * SECS_PER_DAY));       // first days of 1970
        return EPOCH_W'(LATEST_SECS - $urandom_range(0, 40_000_000));   // late 2036 to the end
    endfunction

    //------------------------------------------------------------------
    // Rising edge: record handshakes, queue predictions, check dates,
    // and run the watchdog.
    //------------------------------------------------------------------
    always @(posedge clk) begin : sample_edge
        logic         in_fire;
        logic         out_fire;
        date_t        got;
        date_expect_t want;
        string        diffs;
        in_fire  = rst_n && tx_valid && (epoch_ch.ready === 1'b1);
        out_fire = rst_n && rx_ready && (date_ch.valid === 1'b1);
        in_taken  <= in_fire;
        out_taken <= out_fire;

        if (in_fire)
            dates_expected.push_back('{secs: tx_secs, date: utc_date(tx_secs)});

        if (out_fire) begin
            got.second       = date_ch.second;
            got.minute       = date_ch.minute;
            got.hour         = date_ch.hour;
            got.day_of_month = date_ch.day_of_month;
            got.month_index  = date_ch.month_index;
            got.year         = date_ch.year;
            got.weekday      = date_ch.weekday;
            if (dates_expected.size() == 0) begin
                note_fail($sformatf("unexpected date beat %0d-%0d-%0d", got.year,
                                    got.month_index, got.day_of_month));
            end else begin
                want  = dates_expected.pop_front();
                diffs = "";
                if (got.second !== want.date.second)             diffs = {diffs, " second"};
                if (got.minute !== want.date.minute)             diffs = {diffs, " minute"};
                if (got.hour !== want.date.hour)                 diffs = {diffs, " hour"};
                if (got.day_of_month !== want.date.day_of_month) diffs = {diffs, " day_of_month"};
                if (got.month_index !== want.date.month_index)   diffs = {diffs, " month_index"};
                if (got.year !== want.date.year)                 diffs = {diffs, " year"};
                if (got.weekday !== want.date.weekday)           diffs = {diffs, " weekday"};
                if (diffs != "")
                    note_fail($sformatf({"secs %0d, bad%s: exp %0d/%0d/%0d %0d:%0d:%0d wd %0d,",
                                         " got %0d/%0d/%0d %0d:%0d:%0d wd %0d"},
                        want.secs, diffs,
                        want.date.year, want.date.month_index, want.date.day_of_month,
                        want.date.hour, want.date.minute, want.date.second, want.date.weekday,
                        got.year, got.month_index, got.day_of_month,
                        got.hour, got.minute, got.second, got.weekday));
            end
        end

        // Watchdog: a long hold or a drain pause is far shorter than the limit
        if (in_fire || out_fire)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d dates outstanding",
                     IDLE_LIMIT, dates_expected.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    //------------------------------------------------------------------
    // Sender: works through pending_beats at the falling edge, with a random
    // gap drawn per beat; every so often a run of beats goes
    // back to back. valid gets exactly one assignment per edge.
    //------------------------------------------------------------------
    int tx_gap   = 0;
    int tx_count = 0;
    bit tx_quiet = 1'b0;

    always @(negedge clk) begin : send_beats
        logic offer;
        logic hold_now;
        offer    = tx_valid && !in_taken;   // still waiting on the DUT
        hold_now = 1'b0;
        if (rst_n && !offer) begin
            if (tx_gap != 0) begin
                tx_gap--;
            end else if (pending_beats.size() != 0) begin
                case (pending_beats[0].kind)
                    PEND_SECS: begin
                        tx_secs <= pending_beats[0].secs;
                        void'(pending_beats.pop_front());
                        offer = 1'b1;
                        if (tx_count % 97 == 0)
                            tx_quiet = ($urandom_range(0, 3) == 0);
                        tx_count++;
                        tx_gap = tx_quiet ? 0 : $urandom_range(0, 3);
                    end
                    PEND_DRAIN: begin
                        if (dates_expected.size() == 0)
                            void'(pending_beats.pop_front());
                    end
                    PEND_HOLD: begin
                        hold_now = 1'b1;
                        void'(pending_beats.pop_front());
                    end
                    default: void'(pending_beats.pop_front());
                endcase
            end
        end
        tx_valid <= offer;
        hold_req <= hold_now;
    end

    //------------------------------------------------------------------
    // Receiver: ready at the falling edge, a random stall drawn per beat,
    // plus one long hold-off on request so the DUT backs up its input.
    //------------------------------------------------------------------
    int rx_wait   = 0;
    int rx_count  = 0;
    int hold_left = 0;
    bit rx_quiet  = 1'b0;

    always @(negedge clk) begin : take_beats
        logic rdy;
        rdy = rx_ready && !out_taken;
        if (out_taken) begin
            if (rx_count % 89 == 0)
                rx_quiet = ($urandom_range(0, 3) == 0);
            rx_count++;
        end
        if (rst_n) begin
            if (hold_req)
                hold_left = LONG_HOLD;
            if (hold_left != 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (!rdy) begin
                if (rx_wait != 0) begin
                    rx_wait--;
                end else begin
                    rdy     = 1'b1;
                    rx_wait = rx_quiet ? 0 : $urandom_range(0, 3);
                end
            end
        end
        rx_ready <= rdy;
    end

    //------------------------------------------------------------------
    // Stimulus list, reset, and end of run
    //------------------------------------------------------------------
    initial begin
        // Directed: field extremes and calendar corner cases
        push_secs(0);                       // the epoch itself, a Thursday
        push_secs(LATEST_SECS);             // last representable second, 2038
        push_secs(59);
        push_secs(60);
        push_secs(3599);
        push_secs(3600);
        push_secs(86399);                   // end of the first day
        push_secs(86400);
        push_secs(31535999);                // 1970-12-31 23:59:59, December reached
        push_secs(31536000);                // 1971-01-01
        push_secs(68169600);                // 1972-02-29, first leap day
        push_secs(68255999);                // last second of that leap day
        push_secs(94694399);                // end of leap year 1972
        push_secs(946684799);               // end of 1999
        push_secs(946684800);               // 2000-01-01
        push_secs(951782400);               // 2000-02-29, leap by the 400-year rule
        push_secs(951868800);               // 2000-03-01
        push_secs(1677628799);              // 2023-02-28, common-year February end
        push_secs(1677628800);
        push_secs(2145916799);              // end of 2037
        push_secs(2145916800);              // 2038-01-01
        push_secs(31'h5555_5555);           // alternating bit patterns
        push_secs(31'h2AAA_AAAA);
        push_secs(31'h4000_0000);
        push_marker(PEND_DRAIN);

        // Random part: one long receiver hold while the sender keeps going,
        // and one pause for the pipeline to empty.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 700)
                push_marker(PEND_HOLD);
            if (i == 1000)
                push_marker(PEND_DRAIN);
            push_secs(random_secs());
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_beats.size() != 0 || tx_valid)
            @(posedge clk);
        while (dates_expected.size() != 0)
            @(posedge clk);
        // let any stray extra beat show up before the verdict
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
